FILE: rtl/bba_pkg.sv
// shared types and constants for the buddy block allocator
// no dependencies
`timescale 1ns / 1ps
package bba_pkg;
  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORDER = NUM_ORDERS - 1;
  localparam int LEAF_SHIFT = 4;
  localparam int LEAVES = 1 << TOP_ORDER;
  localparam int LEAF_W = TOP_ORDER;
  localparam int FLAT_BITS = 2 << TOP_ORDER;
  localparam int FLAT_W = TOP_ORDER + 1;
  localparam int ORD_W = 4;
  localparam int LINK_W = LEAF_W + 1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [14:0] request_bytes;
    logic [13:0] free_offset;
  } bba_in_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] block_offset;
    logic [3:0]  block_order;
  } bba_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_A_SCAN, ST_A_POP_RD, ST_A_POP_WR, ST_A_PAIR_RD, ST_A_PAIR_WR,
    ST_A_SPLIT, ST_A_PUSH_RD, ST_A_PUSH_WR, ST_F_SCAN_RD, ST_F_SCAN_CHK, ST_F_PAIR_RD,
    ST_F_PAIR_WR, ST_F_UNL_RD, ST_F_UNL_WR, ST_F_PUSH_RD, ST_F_PUSH_WR, ST_DONE
  } bba_state_t;

  typedef struct packed {
    logic head_empty;
    logic [ORD_W-1:0] k;
    logic [ORD_W-1:0] want;
    logic bit_rd;
    logic clr_last;
    logic leaf_bad;
    logic k_top;
    logic j_end;
  } bba_status_t;

  // first flat bit index of order k
  function automatic logic [FLAT_W-1:0] order_base(input logic [ORD_W-1:0] k);
    logic [FLAT_W:0] full;
    full = (FLAT_W+1)'(FLAT_BITS);
    order_base = FLAT_W'(full - (full >> k));
  endfunction
endpackage

FILE: rtl/bba_ctrl.sv
// controller state machine for the buddy block allocator
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                kind,
  input  logic                out_fire,
  input  bba_pkg::bba_status_t st,
  output bba_pkg::bba_state_t state
);
  import bba_pkg::*;
  bba_state_t state_r, state_nxt;
  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (st.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: if (in_fire) state_nxt = (kind == KIND_FREE) ? ST_F_SCAN_RD : ST_A_SCAN;
      ST_A_SCAN: begin
        if (st.k > ORD_W'(TOP_ORDER)) state_nxt = ST_DONE;
        else if (!st.head_empty) state_nxt = ST_A_POP_RD;
      end
      ST_A_POP_RD: state_nxt = ST_A_POP_WR;
      ST_A_POP_WR: state_nxt = ST_A_PAIR_RD;
      ST_A_PAIR_RD: state_nxt = ST_A_PAIR_WR;
      ST_A_PAIR_WR: state_nxt = (st.k > st.want) ? ST_A_SPLIT : ST_DONE;
      ST_A_SPLIT: state_nxt = ST_A_PUSH_RD;
      ST_A_PUSH_RD: state_nxt = ST_A_PUSH_WR;
      ST_A_PUSH_WR: state_nxt = ST_A_PAIR_RD;
      ST_F_SCAN_RD: state_nxt = st.leaf_bad ? ST_DONE : ST_F_SCAN_CHK;
      ST_F_SCAN_CHK: begin
        if (st.bit_rd || st.j_end) state_nxt = ST_F_PAIR_RD;
        else state_nxt = ST_F_SCAN_RD;
      end
      ST_F_PAIR_RD: state_nxt = st.k_top ? ST_F_PUSH_RD : ST_F_PAIR_WR;
      ST_F_PAIR_WR: state_nxt = st.bit_rd ? ST_F_UNL_RD : ST_F_PUSH_RD;
      ST_F_UNL_RD: state_nxt = ST_F_UNL_WR;
      ST_F_UNL_WR: state_nxt = ST_F_PAIR_RD;
      ST_F_PUSH_RD: state_nxt = ST_F_PUSH_WR;
      ST_F_PUSH_WR: state_nxt = ST_DONE;
      ST_DONE: if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/bba_dp.sv
// datapath: free lists, link memories, pair and split bit memories
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bba_pkg::bba_state_t state,
  input  logic                in_fire,
  input  bba_pkg::bba_in_t    in_item,
  output bba_pkg::bba_status_t st,
  output bba_pkg::bba_out_t   res
);
  import bba_pkg::*;

  logic [LINK_W-1:0] heads_r [NUM_ORDERS];
  logic [LINK_W-1:0] next_mem [LEAVES];
  logic [LINK_W-1:0] prev_mem [LEAVES];
  logic pair_mem [FLAT_BITS];
  logic split_mem [FLAT_BITS];

  logic [ORD_W-1:0] k_r, want_r;
  logic [LEAF_W-1:0] p_r;
  logic ok_r, leaf_bad_r;
  logic [FLAT_W-1:0] clr_r;
  logic [LINK_W-1:0] nx_q, pv_q;
  logic pair_q, split_q;
  logic [LEAF_W-1:0] buddy_leaf;
  logic [LEAF_W-1:0] push_leaf;
  logic [ORD_W-1:0] push_k;
  logic [FLAT_W-1:0] pslot, sslot;
  logic [ORD_W-1:0] want_c;
  logic [LINK_W-1:0] head_k;

  // requested order from byte count: smallest k with 16<<k >= bytes
  always_comb begin
    logic [14:0] b;
    want_c = ORD_W'(NUM_ORDERS);
    b = in_item.request_bytes;
    for (int i = NUM_ORDERS - 1; i >= 0; i--)
      if ((32'(b)) <= (32'(16) << i)) want_c = ORD_W'(i);
  end

  assign head_k = heads_r[k_r];
  assign buddy_leaf = p_r ^ (LEAF_W'(1) << k_r);
  assign pslot = order_base(k_r) + FLAT_W'((p_r >> k_r) >> 1);
  // split slot of the parent order k+1 (scan uses k as j)
  assign sslot = order_base(k_r + ORD_W'(1)) + FLAT_W'(p_r >> (k_r + ORD_W'(1)));
  assign push_k = (state == ST_A_PUSH_RD || state == ST_A_PUSH_WR) ? k_r : k_r;
  assign push_leaf = (state == ST_A_PUSH_RD || state == ST_A_PUSH_WR)
                     ? (p_r + (LEAF_W'(1) << k_r)) : p_r;

  assign st.head_empty = head_k[LINK_W-1];
  assign st.k = k_r;
  assign st.want = want_r;
  // scan: parent split bit; merge: old pair bit set means the buddy is free
  assign st.bit_rd = (state == ST_F_SCAN_CHK) ? split_q : pair_q;
  assign st.clr_last = (clr_r == FLAT_W'(FLAT_BITS - 1));
  assign st.leaf_bad = leaf_bad_r;
  assign st.k_top = (k_r == ORD_W'(TOP_ORDER));
  assign st.j_end = (k_r == ORD_W'(TOP_ORDER - 1));

  // bit memories: clearing sweep, reads registered
  always_ff @(posedge clk) begin
    pair_q <= pair_mem[pslot];
    split_q <= split_mem[sslot];
    if (state == ST_CLEAR) begin
      pair_mem[clr_r] <= 1'b0;
      split_mem[clr_r] <= 1'b0;
    end else if (state == ST_A_PAIR_WR || state == ST_F_PAIR_WR) begin
      pair_mem[pslot] <= ~pair_q;
    end else if (state == ST_A_SPLIT) begin
      split_mem[order_base(k_r) + FLAT_W'(p_r >> k_r)] <= 1'b1;
    end else if (state == ST_F_UNL_RD) begin
      split_mem[sslot] <= 1'b0;
    end
  end

  // link memories: one read address, registered data
  logic [LEAF_W-1:0] lrd;
  always_comb begin
    case (state)
      ST_A_POP_RD: lrd = head_k[LEAF_W-1:0];
      ST_F_UNL_RD: lrd = buddy_leaf;
      default: lrd = head_k[LEAF_W-1:0];
    endcase
  end

  logic [LINK_W-1:0] none_c;
  assign none_c = LINK_W'(LEAVES);

  always_ff @(posedge clk) begin
    nx_q <= next_mem[lrd];
    pv_q <= prev_mem[lrd];
    if (state == ST_A_POP_WR) begin
      if (!nx_q[LINK_W-1]) prev_mem[nx_q[LEAF_W-1:0]] <= none_c;
    end else if (state == ST_A_PUSH_WR || state == ST_F_PUSH_WR) begin
      next_mem[push_leaf] <= head_k;
      prev_mem[push_leaf] <= none_c;
      if (!head_k[LINK_W-1]) prev_mem[head_k[LEAF_W-1:0]] <= {1'b0, push_leaf};
    end else if (state == ST_F_UNL_WR) begin
      if (!pv_q[LINK_W-1]) next_mem[pv_q[LEAF_W-1:0]] <= nx_q;
      if (!nx_q[LINK_W-1]) prev_mem[nx_q[LEAF_W-1:0]] <= pv_q;
    end else if (state == ST_CLEAR && clr_r == '0) begin
      next_mem[0] <= none_c;
      prev_mem[0] <= none_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      for (int i = 0; i < NUM_ORDERS; i++)
        heads_r[i] <= (i == TOP_ORDER) ? '0 : none_c;
    end else begin
      if (state == ST_CLEAR) clr_r <= clr_r + FLAT_W'(1);
      case (state)
        ST_A_POP_WR: heads_r[k_r] <= nx_q;
        ST_A_PUSH_WR, ST_F_PUSH_WR: heads_r[push_k] <= {1'b0, push_leaf};
        ST_F_UNL_WR: if (pv_q[LINK_W-1]) heads_r[k_r] <= nx_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_fire) begin
        want_r <= want_c;
        k_r <= (in_item.kind == KIND_FREE) ? '0 : want_c;
        p_r <= LEAF_W'(in_item.free_offset >> LEAF_SHIFT);
        leaf_bad_r <= 1'b0;
        ok_r <= 1'b0;
      end
      ST_A_SCAN: if (k_r <= ORD_W'(TOP_ORDER) && head_k[LINK_W-1])
        k_r <= k_r + ORD_W'(1);
        else if (k_r <= ORD_W'(TOP_ORDER)) p_r <= head_k[LEAF_W-1:0];
      ST_A_PAIR_WR: if (k_r == want_r) ok_r <= 1'b1;
      ST_A_SPLIT: k_r <= k_r - ORD_W'(1);
      ST_F_SCAN_CHK: begin
        if (split_q) p_r <= p_r & ~((LEAF_W'(1) << k_r) - LEAF_W'(1));
        else if (k_r == ORD_W'(TOP_ORDER - 1)) begin
          k_r <= ORD_W'(TOP_ORDER);
          p_r <= '0;
        end else k_r <= k_r + ORD_W'(1);
      end
      ST_F_UNL_WR: begin
        if (buddy_leaf < p_r) p_r <= buddy_leaf;
        k_r <= k_r + ORD_W'(1);
      end
      ST_F_PUSH_WR: ok_r <= 1'b1;
      default: ;
    endcase
  end

  assign res.ok = ok_r;
  assign res.block_offset = ok_r ? {p_r, 4'b0000} : '0;
  assign res.block_order = ok_r ? k_r : '0;
endmodule

FILE: rtl/buddy_block_allocator.sv
// top level of the buddy block allocator
// depends on bba_pkg, bba_ctrl, bba_dp
`timescale 1ns / 1ps
// allocate scans the orders upward for a free block, pops it, then splits it down order by order;
// free scans the split bits, merges with each free buddy, then pushes the merged block
// throughput: one item at a time, a new item is taken only after the result is transferred
// reset: synchronous active low; then a clearing pass over all 2048 entries of the
// pair and split bit memories during which no item is taken
module buddy_block_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::bba_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::bba_out_t out_data
);
  import bba_pkg::*;
  bba_state_t state;
  bba_status_t st;
  logic in_fire, out_fire;

  // one item in flight; result held in done state until transfer
  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_valid = (state == ST_DONE);
  assign out_fire = out_valid && out_ready;

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .kind(in_data.kind),
    .out_fire(out_fire), .st(st), .state(state)
  );

  bba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .state(state), .in_fire(in_fire),
    .in_item(in_data), .st(st), .res(out_data)
  );

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

  property p_done_follows;
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_ready) |=> out_valid;
  endproperty
  a_done_follows: assert property (p_done_follows) else $error("result dropped");

  property p_order_range;
    @(posedge clk) disable iff (!rst_n) out_valid |-> out_data.block_order <= 4'(TOP_ORDER);
  endproperty
  a_order_range: assert property (p_order_range) else $error("order out of range");
endmodule
